// File: src/hba_pkg.sv
// Shared types and constants for the heap block allocator.
package hba_pkg;

  localparam int unsigned ADDR_W = 20;
  localparam int unsigned SIZE_W = 21;
  localparam int unsigned HEAP_CAP = 1048576;

  localparam logic [0:0] OP_ALLOC = 1'b0;
  localparam logic [0:0] OP_RELEASE = 1'b1;

  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_BEST = 2'd1;
  localparam logic [1:0] FIT_WORST = 2'd2;
  localparam logic [1:0] FIT_NEXT = 2'd3;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_NOMEM = 2'd2;
  localparam logic [1:0] ST_BADREL = 2'd3;

  localparam logic [0:0] REG_FIT_POLICY = 1'b0;
  localparam logic [0:0] REG_HEAP_LIMIT = 1'b1;

  typedef struct packed {
    logic [0:0] operation;
    logic [20:0] request_size;
    logic [19:0] release_address;
  } req_t;

  typedef struct packed {
    logic [19:0] data_address;
    logic [1:0] status;
    logic [0:0] grew_heap;
    logic [1:0] merge_count;
  } rsp_t;

  // One table entry as stored in memory.
  typedef struct packed {
    logic [19:0] offset;
    logic [20:0] size;
    logic free;
  } entry_t;

endpackage

// File: src/heap_block_allocator_top.sv
// Top level of the heap block allocator: request control and block table.
//
// One request is worked at a time. Table reads come from the registered read
// port of the block table memory and changed entries are written back, so a
// request costs more for each table entry visited: an allocate scans up to
// block_count entries (next fit wraps once), and a release scans for its
// address and then shifts the entries above any merged neighbor down one
// place. The result sits in an output register; the next request is taken
// once that result is delivered. The table needs no clearing after reset.
module heap_block_allocator_top #(
  parameter int unsigned MAX_BLOCKS = 64,
  parameter int unsigned HEADER_BYTES = 32
) (
  input logic clk,
  input logic rst,
  input logic in_valid,
  output logic in_ready,
  input hba_pkg::req_t in_data,
  output logic out_valid,
  input logic out_ready,
  output hba_pkg::rsp_t out_data,
  input logic cfg_we,
  input logic [0:0] cfg_index,
  input logic [20:0] cfg_data
);

  localparam int unsigned IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BLOCKS);
  localparam logic [22:0] HDR = 23'(HEADER_BYTES);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_AREAD = 4'd1;   // allocate scan, read issued
  localparam logic [3:0] S_ACHK = 4'd2;    // allocate scan, data back
  localparam logic [3:0] S_ADONE = 4'd3;   // allocate decision
  localparam logic [3:0] S_RREAD = 4'd4;   // release scan
  localparam logic [3:0] S_RCHK = 4'd5;
  localparam logic [3:0] S_NREAD = 4'd6;   // read next neighbor
  localparam logic [3:0] S_NCHK = 4'd7;
  localparam logic [3:0] S_PREAD = 4'd8;   // read previous neighbor
  localparam logic [3:0] S_PCHK = 4'd9;
  localparam logic [3:0] S_SREAD = 4'd10;  // shift entries down
  localparam logic [3:0] S_SWR = 4'd11;
  localparam logic [3:0] S_OUT = 4'd12;

  logic [3:0] state;
  logic [1:0] fit_policy;
  logic [20:0] heap_limit;
  logic [CNT_W-1:0] block_count;
  logic [20:0] heap_top;
  logic [CNT_W-1:0] rover;
  hba_pkg::req_t req;
  hba_pkg::rsp_t rsp;
  logic [21:0] need;
  logic [CNT_W-1:0] step;      // scan iteration
  logic [CNT_W-1:0] pos;       // current table index
  logic [CNT_W-1:0] pick;
  logic pick_ok;
  hba_pkg::entry_t pick_e;
  logic [CNT_W-1:0] idx;       // released entry
  hba_pkg::entry_t cur;        // working copy of released/merged entry
  logic [CNT_W-1:0] rm;        // entry being removed
  logic prev_pending;
  logic [1:0] merges;

  logic we;
  logic [IDX_W-1:0] waddr, raddr;
  hba_pkg::entry_t wdata, rdata;

  logic [CNT_W-1:0] raddr_full;

  hba_table #(.DEPTH(MAX_BLOCKS), .IDX_W(IDX_W)) u_table (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign raddr = raddr_full[IDX_W-1:0];
  assign in_ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign out_data = rsp;

  // Keep the carry of the round-up: a huge request must not wrap to zero
  logic [21:0] need_c;
  assign need_c = (22'(in_data.request_size) + 22'd3) & ~22'd3;

  logic [20:0] lim;
  assign lim = (heap_limit > 21'(hba_pkg::HEAP_CAP)) ? 21'(hba_pkg::HEAP_CAP) : heap_limit;

  logic fits;
  assign fits = rdata.free && ({1'b0, rdata.size} >= need);

  logic [CNT_W-1:0] pos_inc;
  assign pos_inc = (pos + 1'b1 >= block_count) ? '0 : pos + 1'b1;

  always_comb begin
    raddr_full = pos;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fit_policy <= hba_pkg::FIT_FIRST;
      heap_limit <= 21'(hba_pkg::HEAP_CAP);
      block_count <= '0;
      heap_top <= '0;
      rover <= '0;
      we <= 1'b0;
    end else begin
      we <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          hba_pkg::REG_FIT_POLICY: fit_policy <= cfg_data[1:0];
          hba_pkg::REG_HEAP_LIMIT: heap_limit <= cfg_data;
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            req <= in_data;
            need <= need_c;
            merges <= '0;
            step <= '0;
            pick_ok <= 1'b0;
            if (in_data.operation == hba_pkg::OP_ALLOC) begin
              if (need_c == '0) begin
                rsp <= '{data_address: '0, status: hba_pkg::ST_ZERO, grew_heap: 1'b0,
                         merge_count: '0};
                state <= S_OUT;
              end else begin
                rsp <= '0;
                pos <= (fit_policy == hba_pkg::FIT_NEXT && rover < block_count) ? rover : '0;
                state <= (block_count == '0) ? S_ADONE : S_AREAD;
              end
            end else begin
              pos <= '0;
              if (in_data.release_address == '0) begin
                rsp <= '0;
                state <= S_OUT;
              end else if (block_count == '0) begin
                rsp <= '{data_address: '0, status: hba_pkg::ST_BADREL, grew_heap: 1'b0,
                         merge_count: '0};
                state <= S_OUT;
              end else begin
                rsp <= '0;
                state <= S_RREAD;
              end
            end
          end
        end
        S_AREAD: state <= S_ACHK;
        S_ACHK: begin
          if (fits && (!pick_ok ||
              (fit_policy == hba_pkg::FIT_BEST && rdata.size < pick_e.size) ||
              (fit_policy == hba_pkg::FIT_WORST && rdata.size > pick_e.size))) begin
            pick_ok <= 1'b1;
            pick <= pos;
            pick_e <= rdata;
          end
          if ((fits && (fit_policy == hba_pkg::FIT_FIRST || fit_policy == hba_pkg::FIT_NEXT))
              || step + 1'b1 >= block_count) begin
            state <= S_ADONE;
          end else begin
            step <= step + 1'b1;
            pos <= pos_inc;
            state <= S_AREAD;
          end
        end
        S_ADONE: begin
          if (pick_ok) begin
            we <= 1'b1;
            waddr <= pick[IDX_W-1:0];
            wdata <= '{offset: pick_e.offset, size: pick_e.size, free: 1'b0};
            rsp.data_address <= 20'(23'(pick_e.offset) + HDR);
            if (fit_policy == hba_pkg::FIT_NEXT) rover <= pick + 1'b1;
          end else if (block_count < CNT_MAX &&
                       23'(heap_top) + HDR + 23'(need) <= 23'(lim)) begin
            we <= 1'b1;
            waddr <= block_count[IDX_W-1:0];
            wdata <= '{offset: heap_top[19:0], size: need[20:0], free: 1'b0};
            rsp.data_address <= 20'(23'(heap_top) + HDR);
            rsp.grew_heap <= 1'b1;
            block_count <= block_count + 1'b1;
            heap_top <= 21'(23'(heap_top) + HDR + 23'(need));
            if (fit_policy == hba_pkg::FIT_NEXT) rover <= block_count + 1'b1;
          end else begin
            rsp.status <= hba_pkg::ST_NOMEM;
          end
          state <= S_OUT;
        end
        S_RREAD: state <= S_RCHK;
        S_RCHK: begin
          if (23'(rdata.offset) + HDR == 23'(req.release_address)) begin
            if (rdata.free) begin
              rsp.status <= hba_pkg::ST_BADREL;
              state <= S_OUT;
            end else begin
              idx <= pos;
              cur <= '{offset: rdata.offset, size: rdata.size, free: 1'b1};
              we <= 1'b1;
              waddr <= pos[IDX_W-1:0];
              wdata <= '{offset: rdata.offset, size: rdata.size, free: 1'b1};
              if (pos + 1'b1 < block_count) begin
                pos <= pos + 1'b1;
                state <= S_NREAD;
              end else begin
                state <= S_PREAD;
                pos <= pos - 1'b1;
              end
            end
          end else if (pos + 1'b1 >= block_count) begin
            rsp.status <= hba_pkg::ST_BADREL;
            state <= S_OUT;
          end else begin
            pos <= pos + 1'b1;
            state <= S_RREAD;
          end
        end
        S_NREAD: state <= S_NCHK;
        S_NCHK: begin
          if (rdata.free) begin
            cur.size <= 21'(23'(cur.size) + HDR + 23'(rdata.size));
            we <= 1'b1;
            waddr <= idx[IDX_W-1:0];
            wdata <= '{offset: cur.offset,
                       size: 21'(23'(cur.size) + HDR + 23'(rdata.size)), free: 1'b1};
            merges <= merges + 1'b1;
            rsp.merge_count <= merges + 1'b1;
            rm <= idx + 1'b1;
            pos <= idx + 2'd2;
            prev_pending <= 1'b1;
            state <= S_SREAD;
          end else begin
            pos <= idx - 1'b1;
            state <= S_PREAD;
          end
        end
        S_PREAD: begin
          // idx 0 has no previous neighbor
          if (idx == '0) state <= S_OUT;
          else state <= S_PCHK;
        end
        S_PCHK: begin
          prev_pending <= 1'b0;
          if (rdata.free) begin
            we <= 1'b1;
            waddr <= pos[IDX_W-1:0];
            wdata <= '{offset: rdata.offset,
                       size: 21'(23'(rdata.size) + HDR + 23'(cur.size)), free: 1'b1};
            merges <= merges + 1'b1;
            rsp.merge_count <= merges + 1'b1;
            rm <= idx;
            pos <= idx + 1'b1;
            state <= S_SREAD;
          end else begin
            state <= S_OUT;
          end
        end
        S_SREAD: begin
          // move entry pos down to pos-1, or finish the removal
          if (pos >= block_count) begin
            block_count <= block_count - 1'b1;
            if (rover > rm) rover <= rover - 1'b1;
            if (prev_pending) begin
              prev_pending <= 1'b0;
              pos <= idx - 1'b1;
              state <= S_PREAD;
            end else begin
              state <= S_OUT;
            end
          end else begin
            state <= S_SWR;
          end
        end
        S_SWR: begin
          we <= 1'b1;
          waddr <= IDX_W'(pos - 1'b1);
          wdata <= rdata;
          pos <= pos + 1'b1;
          state <= S_SREAD;
        end
        S_OUT: begin
          if (out_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: src/hba_table.sv
// Block table memory: one write port, one registered read port.
module hba_table #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned IDX_W = 6
) (
  input logic clk,
  input logic we,
  input logic [IDX_W-1:0] waddr,
  input hba_pkg::entry_t wdata,
  input logic [IDX_W-1:0] raddr,
  output hba_pkg::entry_t rdata
);

  hba_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
